/* rtl/tkdlp_pkg.sv */
// ----------------------------------------------------------------------------
// Two-key debounce package
// Shared types, register codes and helpers for the two-key debounce,
// long-press and auto-repeat unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tkdlp_pkg;

    localparam int unsigned TickW = 16;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [TickW-1:0] DebounceReset  = 16'd20;
    localparam logic [TickW-1:0] LongPressReset = 16'd1000;
    localparam logic [TickW-1:0] RepeatReset    = 16'd200;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_REPEAT     = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_DEBOUNCE   = 2'd0,
        PH_LONG       = 2'd1,
        PH_REPEAT     = 2'd2,
        PH_UP_PENDING = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_DOWN        = 2'd0,
        EV_UP          = 2'd1,
        EV_LONG_PRESS  = 2'd2,
        EV_LONG_REPEAT = 2'd3
    } ev_kind_t;

    typedef struct packed {
        logic key1_pressed;
        logic key0_pressed;
    } in_t;

    typedef struct packed {
        logic       key_id;
        logic [1:0] event_kind;
    } out_t;

    // Event produced by one tick, handed from the core to the output stage.
    typedef struct packed {
        logic valid;
        out_t data;
    } res_t;

    // A period register of zero still gives the shortest period.
    function automatic logic [TickW-1:0] period_of(input logic [TickW-1:0] r);
        return (r == '0) ? TickW'(1) : r;
    endfunction

endpackage

`default_nettype wire

/* rtl/two_key_debounce_long_press_repeat_unit.sv */
// An event is registered in the output stage before it shows on out_valid.
// One tick per cycle while in_stall is low; the core is combinational.
// A two-entry output stage (register plus skid) keeps input open while one
// event waits; in_stall rises only when both entries hold events.
// Reset: asynchronous, active low; registers return to 20/1000/200 ticks,
// the slot is freed, both keys read as released and no event is pending.
// ----------------------------------------------------------------------------
// Two-key debounce, long-press and auto-repeat unit
// Top level: tick input channel, configuration port and event output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module two_key_debounce_long_press_repeat_unit
    import tkdlp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [TickW-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire in_t                in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output out_t                    out_data
);

    logic tick;
    res_t res;

    logic out_valid_reg;
    out_t out_data_reg;
    logic skid_valid_reg;
    out_t skid_data_reg;

    assign in_stall  = skid_valid_reg;
    assign tick      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tkdlp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick),
        .item      (in_data),
        .res       (res)
    );

    // The skid entry only fills while the output register is full and stalled,
    // so it is always older than any new event.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else begin
                out_valid_reg <= tick && res.valid;
            end
        end
        else if (tick && res.valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!out_valid_reg || !out_stall) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res.data;
        end
        else if (tick && res.valid) begin
            skid_data_reg <= res.data;
        end
    end

endmodule

`default_nettype wire

/* rtl/tkdlp_core.sv */
// ----------------------------------------------------------------------------
// Two-key debounce core
// Holds the configuration and the slot state, and works out each tick
// combinationally: edges of both keys first, then the countdown.
// ----------------------------------------------------------------------------
`default_nettype none

module tkdlp_core
    import tkdlp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [TickW-1:0]   cfg_data,
    input  wire logic               tick,
    input  wire in_t                item,
    output res_t                    res
);

    logic [TickW-1:0] debounce_reg;
    logic [TickW-1:0] long_press_reg;
    logic [TickW-1:0] repeat_reg;

    logic [1:0]       prev_reg;
    logic             busy_reg, busy_next;
    logic             claimed_reg, claimed_next;
    phase_t           phase_reg, phase_next;
    logic [TickW-1:0] count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            debounce_reg   <= DebounceReset;
            long_press_reg <= LongPressReset;
            repeat_reg     <= RepeatReset;
        end
        else if (cfg_write) begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                CFG_LONG_PRESS: long_press_reg <= cfg_data;
                CFG_REPEAT:     repeat_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb begin
        logic [1:0]       levels;
        logic             loaded;
        logic             held;
        logic [TickW-1:0] dec;

        levels       = {item.key1_pressed, item.key0_pressed};
        loaded       = 1'b0;
        busy_next    = busy_reg;
        claimed_next = claimed_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        res          = '0;

        // Key 0 is handled before key 1, so a shared press goes to key 0.
        for (int i = 0; i < 2; i++) begin
            if (levels[i] && !prev_reg[i]) begin
                if (!busy_next) begin
                    busy_next    = 1'b1;
                    claimed_next = 1'(i);
                    phase_next   = PH_DEBOUNCE;
                    count_next   = period_of(debounce_reg);
                    loaded       = 1'b1;
                end
                else if (claimed_next == 1'(i) && phase_next == PH_DEBOUNCE) begin
                    count_next = period_of(debounce_reg);
                    loaded     = 1'b1;
                end
            end
            else if (!levels[i] && prev_reg[i]) begin
                if (busy_next && claimed_next == 1'(i)
                    && (phase_next == PH_LONG || phase_next == PH_REPEAT)) begin
                    phase_next = PH_UP_PENDING;
                    count_next = TickW'(1);
                    loaded     = 1'b1;
                end
            end
        end

        dec  = count_next - TickW'(1);
        held = levels[claimed_next];

        if (!loaded && count_next != '0) begin
            count_next = dec;
            if (dec == '0 && busy_next) begin
                res.data.key_id = claimed_next;
                res.valid       = 1'b1;
                unique case (phase_next)
                    PH_DEBOUNCE: begin
                        if (held) begin
                            phase_next          = PH_LONG;
                            count_next          = period_of(long_press_reg);
                            res.data.event_kind = EV_DOWN;
                        end
                        else begin
                            busy_next = 1'b0;
                            res.valid = 1'b0;
                        end
                    end
                    PH_LONG: begin
                        if (held) begin
                            phase_next          = PH_REPEAT;
                            count_next          = period_of(repeat_reg);
                            res.data.event_kind = EV_LONG_PRESS;
                        end
                        else begin
                            busy_next           = 1'b0;
                            res.data.event_kind = EV_UP;
                        end
                    end
                    PH_REPEAT: begin
                        if (held) begin
                            count_next          = period_of(repeat_reg);
                            res.data.event_kind = EV_LONG_REPEAT;
                        end
                        else begin
                            busy_next           = 1'b0;
                            res.data.event_kind = EV_UP;
                        end
                    end
                    default: begin
                        busy_next           = 1'b0;
                        res.data.event_kind = EV_UP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prev_reg    <= '0;
            busy_reg    <= 1'b0;
            claimed_reg <= 1'b0;
            phase_reg   <= PH_DEBOUNCE;
            count_reg   <= '0;
        end
        else if (tick) begin
            prev_reg    <= {item.key1_pressed, item.key0_pressed};
            busy_reg    <= busy_next;
            claimed_reg <= claimed_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/tkdlp_checker.sv */
// ----------------------------------------------------------------------------
// Two-key debounce port checker
// Watches the top level's ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tkdlp_checker
    import tkdlp_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire out_t out_data
);

    // A waiting event is not dropped or changed.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output event changed while stalled");

    // Input is only held off when an event is waiting at the output.
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // The input side closes only after the output side was stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall without output back-pressure");

    // An event out of an empty output stage comes from a tick transfer.
    a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("event appeared without a tick transfer");

endmodule

bind two_key_debounce_long_press_repeat_unit tkdlp_checker u_tkdlp_checker (.*);

`default_nettype wire
